// ===== hdl/mhns_pkg.sv =====
// mhns_pkg: widths, register indexes and sequencer states shared by the
// min-wise hash neighbour select block and its channel interfaces.
// No dependencies.
package mhns_pkg;

  localparam int NODE_BITS    = 32;
  localparam int SRC_BITS     = 32;
  localparam int REG_BITS     = 63;
  localparam int HASH_BITS    = 64;
  localparam int CHOSEN_BITS  = SRC_BITS + 1;
  localparam int CFG_IDX_BITS = 2;
  localparam int MUL_LO_BITS  = 32;
  localparam int MUL_HI_BITS  = REG_BITS - MUL_LO_BITS;
  localparam int PROD_BITS    = NODE_BITS + MUL_LO_BITS;
  localparam int ACC_BITS     = NODE_BITS + REG_BITS + 1;
  localparam int CNT_BITS     = $clog2(ACC_BITS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MULTIPLIER = 2'd0,
    CFG_OFFSET     = 2'd1,
    CFG_MODULUS    = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_REDUCE,
    ST_UPDATE
  } state_t;

endpackage

// ===== hdl/mhns_if.sv =====
// mhns_if: valid/ready channel interfaces for neighbour items, selection
// results and configuration writes.
// Depends on mhns_pkg.
interface mhns_req_if import mhns_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SRC_BITS-1:0]  source_node;
  logic [NODE_BITS-1:0] neighbour_id;
  logic                 last;
  logic                 empty_req;

  modport source (output valid, source_node, neighbour_id, last, empty_req, input ready);
  modport sink   (input valid, source_node, neighbour_id, last, empty_req, output ready);
endinterface

interface mhns_rsp_if import mhns_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic        [SRC_BITS-1:0]    result_source;
  logic signed [CHOSEN_BITS-1:0] chosen_node;

  modport source (output valid, result_source, chosen_node, input ready);
  modport sink   (input valid, result_source, chosen_node, output ready);
endinterface

interface mhns_cfg_if import mhns_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [REG_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/minhash_neighbour_select.sv =====
// minhash_neighbour_select: picks one neighbour per node by min-wise hashing.
// Depends on mhns_pkg and the channel interfaces in mhns_if.
//
// Each neighbour item is hashed as (id * a + b) mod m and the neighbour with
// the smallest hash is kept, the earlier one winning a tie; the item marked
// last delivers it with its source node, an item marked empty delivers -1.
// From acceptance until the block is ready again, a neighbour item passes
// twice through one 32x32 multiplier with 96-bit adds of the offset and the
// high product, then a bit-serial remainder taking one bit of the 96-bit sum
// per cycle, then the minimum update. Empty items skip to the update. A result
// sits in an output register; a final or empty item waits in its last cycle
// only while the previous result has not yet been taken. Configuration writes
// are taken in any cycle and must only be issued while the block is idle.
module minhash_neighbour_select import mhns_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mhns_cfg_if.sink   cfg,
  mhns_req_if.sink   req,
  mhns_rsp_if.source rsp
);

  state_t state, state_next;

  logic [REG_BITS-1:0]    mult, mult_next;
  logic [REG_BITS-1:0]    offset, offset_next;
  logic [REG_BITS-1:0]    modulus, modulus_next;
  logic [HASH_BITS-1:0]   best_hash, best_hash_next;
  logic [SRC_BITS-1:0]    best_node, best_node_next;
  logic [SRC_BITS-1:0]    src, src_next;
  logic [NODE_BITS-1:0]   node, node_next;
  logic                   last_q, last_q_next;
  logic                   empty_q, empty_q_next;
  logic [PROD_BITS-1:0]   prod, prod_next;
  logic [ACC_BITS-1:0]    acc, acc_next;
  logic [REG_BITS-1:0]    rem, rem_next;
  logic [CNT_BITS-1:0]    cnt, cnt_next;
  logic                   out_valid, out_valid_next;
  logic [SRC_BITS-1:0]    out_source, out_source_next;
  logic [CHOSEN_BITS-1:0] out_chosen, out_chosen_next;

  logic [REG_BITS-1:0]    mod_eff;
  logic [REG_BITS:0]      trial;
  logic [REG_BITS:0]      diff;
  logic                   fits;
  logic [MUL_LO_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0]   mul_p;
  logic [HASH_BITS-1:0]   hash;
  logic                   better;
  logic                   blocked;
  logic [SRC_BITS-1:0]    win_node;

  assign cfg.ready         = 1'b1;
  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.result_source = out_source;
  assign rsp.chosen_node   = out_chosen;

  // shared datapath
  assign mod_eff = (modulus == '0) ? REG_BITS'(1) : modulus;
  assign trial   = {rem, acc[ACC_BITS-1]};
  assign diff    = trial - {1'b0, mod_eff};
  assign fits    = (trial >= {1'b0, mod_eff});
  assign mul_b   = (state == ST_MUL_LO) ? mult[MUL_LO_BITS-1:0]
                                        : MUL_LO_BITS'(mult[REG_BITS-1:MUL_LO_BITS]);
  assign mul_p   = PROD_BITS'(node) * PROD_BITS'(mul_b);
  assign hash    = HASH_BITS'(rem);
  assign better  = (hash < best_hash);
  assign win_node = better ? SRC_BITS'(node) : best_node;
  assign blocked = (last_q | empty_q) & out_valid & ~rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mult      <= '0;
      offset    <= '0;
      modulus   <= REG_BITS'(1);
      best_hash <= '1;
      best_node <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mult      <= mult_next;
      offset    <= offset_next;
      modulus   <= modulus_next;
      best_hash <= best_hash_next;
      best_node <= best_node_next;
      out_valid <= out_valid_next;
    end
    src        <= src_next;
    node       <= node_next;
    last_q     <= last_q_next;
    empty_q    <= empty_q_next;
    prod       <= prod_next;
    acc        <= acc_next;
    rem        <= rem_next;
    cnt        <= cnt_next;
    out_source <= out_source_next;
    out_chosen <= out_chosen_next;
  end

  always_comb begin
    state_next      = state;
    mult_next       = mult;
    offset_next     = offset;
    modulus_next    = modulus;
    best_hash_next  = best_hash;
    best_node_next  = best_node;
    src_next        = src;
    node_next       = node;
    last_q_next     = last_q;
    empty_q_next    = empty_q;
    prod_next       = prod;
    acc_next        = acc;
    rem_next        = rem;
    cnt_next        = cnt;
    out_valid_next  = out_valid & ~rsp.ready;
    out_source_next = out_source;
    out_chosen_next = out_chosen;

    if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MULTIPLIER: mult_next    = cfg.data;
        CFG_OFFSET:     offset_next  = cfg.data;
        CFG_MODULUS:    modulus_next = cfg.data;
        default: ;
      endcase
    end

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          src_next     = req.source_node;
          node_next    = req.neighbour_id;
          last_q_next  = req.last;
          empty_q_next = req.empty_req;
          state_next   = req.empty_req ? ST_UPDATE : ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        prod_next  = mul_p;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        acc_next   = ACC_BITS'(prod) + ACC_BITS'(offset);
        prod_next  = mul_p;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        acc_next   = acc + {prod[ACC_BITS-MUL_LO_BITS-1:0], {MUL_LO_BITS{1'b0}}};
        rem_next   = '0;
        cnt_next   = CNT_BITS'(ACC_BITS - 1);
        state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        rem_next = fits ? diff[REG_BITS-1:0] : trial[REG_BITS-1:0];
        acc_next = acc << 1;
        cnt_next = cnt - CNT_BITS'(1);
        if (cnt == '0) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!blocked) begin
          state_next = ST_IDLE;
          priority if (empty_q) begin
            best_hash_next  = '1;
            best_node_next  = '0;
            out_valid_next  = 1'b1;
            out_source_next = src;
            out_chosen_next = '1;
          end else if (last_q) begin
            best_hash_next  = '1;
            best_node_next  = win_node;
            out_valid_next  = 1'b1;
            out_source_next = src;
            out_chosen_next = {1'b0, win_node};
          end else begin
            best_hash_next = better ? hash : best_hash;
            best_node_next = win_node;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== test/minhash_neighbour_select_test.sv =====
// minhash_neighbour_select_test: self-checking bench for the min-wise hash neighbour
// select block, driving random and directed neighbour streams under several hash settings.
// Depends on mhns_pkg, the channel interfaces in mhns_if and minhash_neighbour_select.
module minhash_neighbour_select_test import mhns_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 120;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 85;

  typedef struct packed {
    logic [SRC_BITS-1:0]    source;
    logic [CHOSEN_BITS-1:0] chosen;
  } selection_t;

  class selection_scoreboard;
    logic [REG_BITS-1:0]  multiplier;
    logic [REG_BITS-1:0]  offset;
    logic [REG_BITS-1:0]  modulus;
    logic [HASH_BITS-1:0] best_hash;
    logic [NODE_BITS-1:0] best_node;
    selection_t           pending_selections[$];
    int                   mismatches;
    int                   items_seen;
    int                   selections_seen;

    function new();
      multiplier      = '0;
      offset          = '0;
      modulus         = REG_BITS'(1);
      best_hash       = '1;
      best_node       = '0;
      mismatches      = 0;
      items_seen      = 0;
      selections_seen = 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [REG_BITS-1:0] value);
      case (idx)
        CFG_MULTIPLIER: multiplier = value;
        CFG_OFFSET:     offset = value;
        CFG_MODULUS:    modulus = value;
        default: ;
      endcase
    endfunction

    function void enqueue_selection(selection_t sel);
      pending_selections = {pending_selections, sel};
    endfunction

    function logic [HASH_BITS-1:0] neighbour_hash(logic [NODE_BITS-1:0] id);
      logic [127:0] sum;
      logic [127:0] divisor;
      sum = 128'(id) * 128'(multiplier) + 128'(offset);
      divisor = (modulus == '0) ? 128'd1 : 128'(modulus);
      return HASH_BITS'(sum % divisor);
    endfunction

    function void track_minimum(logic [SRC_BITS-1:0] src, logic [NODE_BITS-1:0] nb,
                                logic last_flag, logic empty_flag);
      selection_t           sel;
      logic [HASH_BITS-1:0] h;
      items_seen++;
      sel.source = src;
      if (empty_flag) begin
        best_hash = '1;
        best_node = '0;
        sel.chosen = '1;
        enqueue_selection(sel);
        return;
      end
      h = neighbour_hash(nb);
      if (h < best_hash) begin
        best_hash = h;
        best_node = nb;
      end
      if (last_flag) begin
        sel.chosen = {1'b0, best_node};
        enqueue_selection(sel);
        best_hash = '1;
      end
    endfunction

    function void check_selection(logic [SRC_BITS-1:0] src, logic [CHOSEN_BITS-1:0] chosen);
      selection_t want;
      selections_seen++;
      if (pending_selections.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: source %h chosen %h", src, chosen);
        return;
      end
      want = pending_selections.pop_front();
      if (src !== want.source || chosen !== want.chosen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: source exp %h got %h, chosen exp %h got %h",
                   want.source, src, want.chosen, chosen);
      end
    endfunction

    function int pending();
      return pending_selections.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   hold_left;
  int   settings_count;

  selection_scoreboard book = new();

  mhns_cfg_if cfg_ch();
  mhns_req_if req_ch();
  mhns_rsp_if rsp_ch();

  minhash_neighbour_select u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int idle_cycles();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic logic [REG_BITS-1:0] rand_reg();
    return REG_BITS'({$urandom(), $urandom()});
  endfunction

  function automatic logic [REG_BITS-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return REG_BITS'($urandom_range(1, 1000));
      3: return REG_BITS'($urandom());
      default: return rand_reg();
    endcase
  endfunction

  function automatic logic [REG_BITS-1:0] pick_modulus();
    case ($urandom_range(0, 4))
      0: return REG_BITS'(1);
      1: return '1;
      2: return REG_BITS'($urandom_range(2, 17));
      3: return REG_BITS'($urandom_range(1000, 1000003));
      default: return rand_reg() | REG_BITS'(1);
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      hold_left <= idle_cycles();
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      book.check_selection(rsp_ch.result_source, rsp_ch.chosen_node);
  end

  task automatic send_item(logic [SRC_BITS-1:0] src, logic [NODE_BITS-1:0] nb,
                           logic last_flag, logic empty_flag);
    int gap;
    gap = idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.source_node  <= src;
    req_ch.neighbour_id <= nb;
    req_ch.last         <= last_flag;
    req_ch.empty_req    <= empty_flag;
    do @(posedge clk); while (!req_ch.ready);
    book.track_minimum(src, nb, last_flag, empty_flag);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [REG_BITS-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    book.set_register(idx, value);
  endtask

  task automatic write_settings(logic [REG_BITS-1:0] mult, logic [REG_BITS-1:0] offs,
                                logic [REG_BITS-1:0] modl);
    write_reg(CFG_MULTIPLIER, mult);
    write_reg(CFG_OFFSET, offs);
    write_reg(CFG_MODULUS, modl);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings_count++;
  endtask

  // block may still be hashing an item that gives no result
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(int target);
    int                   sent;
    int                   kind;
    int                   n;
    bit                   narrow;
    logic [SRC_BITS-1:0]  src;
    logic [NODE_BITS-1:0] nb;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 99);
      src = $urandom();
      if (kind < 75) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        narrow = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) begin
          nb = narrow ? NODE_BITS'($urandom_range(0, 7)) : NODE_BITS'($urandom());
          send_item(src, nb, i == n - 1, 1'b0);
        end
        sent += n;
      end else if (kind < 87) begin
        send_item(src, $urandom(), 1'($urandom_range(0, 1)), 1'b1);
        sent++;
      end else begin
        // scan cut short, continued by whatever follows
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_item($urandom(), $urandom(), 1'b0, 1'b0);
        sent += n;
      end
    end
  endtask

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    calm                = 1'b0;
    hold_left           = 0;
    settings_count      = 0;
    req_ch.valid        = 1'b0;
    req_ch.source_node  = '0;
    req_ch.neighbour_id = '0;
    req_ch.last         = 1'b0;
    req_ch.empty_req    = 1'b0;
    rsp_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_MULTIPLIER;
    cfg_ch.data         = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: every hash is zero, so the first neighbour wins
    send_item(32'd1, 32'd5, 1'b0, 1'b0);
    send_item(32'd1, 32'd7, 1'b0, 1'b0);
    send_item(32'd1, 32'd9, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1);
    send_item(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    drain();

    write_settings('1, '1, '1);
    send_item(32'd0, 32'd0, 1'b0, 1'b0);
    send_item(32'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    drain();

    // zero modulus acts as one
    write_settings(REG_BITS'(3), REG_BITS'(5), '0);
    send_item(32'd7, 32'd100, 1'b0, 1'b0);
    send_item(32'd7, 32'd50, 1'b1, 1'b0);
    drain();

    // empty item in the middle of a scan drops what was scanned
    write_settings(REG_BITS'(12345), REG_BITS'(678), REG_BITS'(1000003));
    send_item(32'd8, 32'd11, 1'b0, 1'b0);
    send_item(32'd8, 32'd22, 1'b0, 1'b0);
    send_item(32'd8, 32'd0, 1'b0, 1'b1);
    send_item(32'd9, 32'd33, 1'b0, 1'b0);
    send_item(32'd9, 32'd44, 1'b0, 1'b0);
    send_item(32'd9, 32'd55, 1'b1, 1'b0);
    send_item(32'd10, 32'd33, 1'b1, 1'b0);
    drain();

    write_settings('0, '1, REG_BITS'(17));
    send_item(32'd11, 32'd3, 1'b0, 1'b0);
    send_item(32'd11, 32'd4, 1'b1, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      write_settings(pick_value(), pick_value(), pick_modulus());
      run_random_phase(PHASE_ITEMS);
      drain();
    end

    $display("run covered %0d neighbour items under %0d hash settings, %0d selections checked",
             book.items_seen, settings_count, book.selections_seen);
    if (book.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", book.mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
